// File: design/palette_frame_store_rgb888_core_macros.svh
// assertion macros shared by the palette frame store design
// no dependencies; included by files that carry concurrent checks
`ifndef PALETTE_FRAME_STORE_RGB888_CORE_MACROS_SVH
`define PALETTE_FRAME_STORE_RGB888_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfs check failed");

// next-cycle implication, disabled while reset is low
`define PFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfs check failed");

`endif

// File: design/pfs_pkg.sv
// types, constants and conversion tables for the palette frame store
// no dependencies; imported by every module of the block
package pfs_pkg;

  localparam int ADDR_W      = 8;
  localparam int STORE_BYTES = 1 << ADDR_W;
  localparam int Q_AW        = 2;
  localparam int Q_DEPTH     = 1 << Q_AW;

  // yuv fixed point: channel sums are in units of 1/1200000
  localparam int Y_COEF     = 100000;
  localparam int RV_COEF    = 128033;
  localparam int GU_COEF    = -21482;
  localparam int GV_COEF    = -38059;
  localparam int BU_COEF    = 212798;
  localparam int FULL_SCALE = 1200000;

  localparam logic [2:0] MODE_RAW      = 3'd0;
  localparam logic [2:0] MODE_UNIFORM  = 3'd1;
  localparam logic [2:0] MODE_RGB332   = 3'd2;
  localparam logic [2:0] MODE_GRADIENT = 3'd3;
  localparam logic [2:0] MODE_YUV      = 3'd4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          data;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [23:0] rgb_t;
  typedef rgb_t [255:0] yuv_lut_t;

  function automatic int chroma12(int c);
    int d;
    d = c - 4;
    return (d < 0) ? d * 3 : d * 4;
  endfunction

  function automatic logic [7:0] yuv_chan(int n);
    int m;
    m = n;
    if (m < 0) m = 0;
    if (m > FULL_SCALE) m = FULL_SCALE;
    return 8'((m * 255) / FULL_SCALE);
  endfunction

  // evaluated at elaboration only
  function automatic yuv_lut_t build_yuv_lut();
    yuv_lut_t lut;
    int y12;
    int u12;
    int v12;
    int base;
    for (int code = 0; code < 256; code++) begin
      y12  = (code & 3) * 4;
      u12  = chroma12((code >> 2) & 7);
      v12  = chroma12((code >> 5) & 7);
      base = Y_COEF * y12;
      lut[code] = {yuv_chan(base + RV_COEF * v12),
                   yuv_chan(base + GU_COEF * u12 + GV_COEF * v12),
                   yuv_chan(base + BU_COEF * u12)};
    end
    return lut;
  endfunction

  localparam yuv_lut_t YUV_LUT = build_yuv_lut();

endpackage

// File: design/pfs_if.sv
// valid/ready channel interfaces of the palette frame store
// no dependencies; used by the top level and the front and back modules
interface pfs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       message_start;
  logic       peer_ready;
  logic [7:0] read_address;
  modport source (output valid, kind, data_byte, message_start, peer_ready, read_address,
                  input ready);
  modport sink   (input valid, kind, data_byte, message_start, peer_ready, read_address,
                  output ready);
endinterface

interface pfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_code;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, pixel_code, red, green, blue, input ready);
  modport sink   (input valid, pixel_code, red, green, blue, output ready);
endinterface

interface pfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] colour_mode;
  modport source (output valid, colour_mode, input ready);
  modport sink   (input valid, colour_mode, output ready);
endinterface

// File: design/palette_frame_store_rgb888_core.sv
// palette frame store top level: config register, front end, queue, back end
// depends on pfs_pkg, pfs_if, pfs_front, pfs_fifo, pfs_back and the macro header
//
// in_ch carries message bytes (kind 0) and pixel reads (kind 1); a transfer
// happens when valid and ready are both high. message bytes fill a 256-byte
// pixel store: a start byte sets the write offset if peer_ready is high, and
// later bytes write consecutive addresses, wrapping around. a read returns the
// stored code and its rgb888 colour on out_ch under the mode held in the
// colour_mode register, written through cfg_ch (always ready); the user must
// write it only while idle, which the block does not enforce. one item per
// cycle is sustained while out_ch is ready, set by the single store port in
// the back end. a four-entry queue sits between the front end and the back
// end, so input keeps flowing while out_ch stalls until the queue and the
// two back end stages are full; then in_ch.ready drops. message bytes give
// no result. reset clears the message state, the mode register, the queue
// and the per-entry valid bits, so the whole store reads as zero right away.
`include "palette_frame_store_rgb888_core_macros.svh"

module palette_frame_store_rgb888_core import pfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pfs_in_if.sink     in_ch,
  pfs_out_if.source  out_ch,
  pfs_cfg_if.sink    cfg_ch
);

  logic [2:0] colour_mode_r;
  logic       push, pop;
  op_t        push_op, head_op;
  q_status_t  q_status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_mode_r <= MODE_RAW;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      colour_mode_r <= cfg_ch.colour_mode;
    end
  end

  pfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_op  (push_op)
  );

  pfs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  pfs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .colour_mode (colour_mode_r),
    .q_status    (q_status),
    .head_op     (head_op),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  `PFS_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !q_status.full)
  `PFS_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, pop, !q_status.empty)
  `PFS_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push && !pop, !q_status.empty)

endmodule

// File: design/pfs_front.sv
// front end: accepts items, tracks message state, queues store writes and reads
// depends on pfs_pkg and pfs_in_if
module pfs_front import pfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pfs_in_if.sink    in_ch,
  input  q_status_t q_status,
  output logic      push,
  output op_t       push_op
);

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic              msg_en_r, msg_en_nxt;
  logic              accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    msg_en_nxt   = msg_en_r;
    push         = 1'b0;
    push_op.kind = OP_READ;
    push_op.addr = in_ch.read_address[ADDR_W-1:0];
    push_op.data = in_ch.data_byte;
    if (accept) begin
      if (in_ch.kind) begin
        push = 1'b1;
      end else if (in_ch.message_start) begin
        msg_en_nxt = in_ch.peer_ready;
        if (in_ch.peer_ready) wr_ptr_nxt = in_ch.data_byte[ADDR_W-1:0];
      end else if (msg_en_r) begin
        push         = 1'b1;
        push_op.kind = OP_WRITE;
        push_op.addr = wr_ptr_r;
        wr_ptr_nxt   = wr_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      msg_en_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      msg_en_r <= msg_en_nxt;
    end
  end

endmodule

// File: design/pfs_fifo.sv
// short operation queue between the front and back ends
// depends on pfs_pkg
module pfs_fifo import pfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head_op,
  output q_status_t status
);

  op_t             q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_idx_r, rd_idx_r;
  logic [Q_AW:0]   count_r;

  assign head_op      = q_mem[rd_idx_r];
  assign status.full  = (count_r == (Q_AW + 1)'(Q_DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_idx_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_idx_r <= wr_idx_r + 1'b1;
      if (pop)  rd_idx_r <= rd_idx_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/pfs_back.sv
// back end: pixel store memory, read stage, colour conversion, output register
// depends on pfs_pkg and pfs_out_if
module pfs_back import pfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] colour_mode,
  input  q_status_t  q_status,
  input  op_t        head_op,
  output logic       pop,
  pfs_out_if.source  out_ch
);

  logic [7:0]             store_mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] store_vld_r;
  logic [7:0]             rd_data_r;
  logic                   rd_vld_r;
  logic                   s1_v_r;
  logic                   out_v_r;
  logic [7:0]             code_r, red_r, green_r, blue_r;
  logic                   out_load, s1_free, pop_rd, pop_wr;
  logic [7:0]             code;
  rgb_t                   rgb;
  logic [5:0]             grad_v;
  logic [7:0]             grad_on;
  logic [1:0]             uni_f;

  assign out_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign s1_free  = !s1_v_r || out_load;
  assign pop      = !q_status.empty && ((head_op.kind == OP_WRITE) || s1_free);
  assign pop_rd   = pop && (head_op.kind == OP_READ);
  assign pop_wr   = pop && (head_op.kind == OP_WRITE);

  // entries never written read as zero
  assign code = rd_vld_r ? rd_data_r : 8'h00;

  always_comb begin
    grad_v  = {1'b0, code[4:0]} + 6'd1;
    grad_on = grad_v[5] ? 8'hFF : {grad_v[4:0], 3'b000};
    uni_f   = code[7:6];
    unique case (colour_mode)
      MODE_UNIFORM:  rgb = {code[5:4], code[7:6], code[5:4], code[7:6],
                            code[3:2], code[7:6], code[3:2], code[7:6],
                            code[1:0], uni_f, code[1:0], uni_f};
      MODE_RGB332:   rgb = {code[7:5], code[7:5], code[7:6],
                            code[4:2], code[4:2], code[4:3],
                            code[1:0], code[1:0], code[1:0], code[1:0]};
      MODE_GRADIENT: rgb = {code[7] ? grad_on : 8'h00,
                            code[6] ? grad_on : 8'h00,
                            code[5] ? grad_on : 8'h00};
      MODE_YUV:      rgb = YUV_LUT[code];
      default:       rgb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_wr) store_mem[head_op.addr] <= head_op.data;
    if (pop_rd) rd_data_r <= store_mem[head_op.addr];
  end

  always_ff @(posedge clk) begin
    if (pop_rd) rd_vld_r <= store_vld_r[head_op.addr];
    if (out_load) begin
      code_r  <= code;
      red_r   <= rgb[23:16];
      green_r <= rgb[15:8];
      blue_r  <= rgb[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_vld_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (pop_wr) store_vld_r[head_op.addr] <= 1'b1;
      if (pop_rd)        s1_v_r <= 1'b1;
      else if (out_load) s1_v_r <= 1'b0;
      if (out_load)          out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.pixel_code = code_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;

endmodule
